>>> rtl/core/wav_header_parser_assert.svh
// ----------------------------------------------------------------------------
// WAV header parser assertion macros
// Concurrent checks clocked by clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef WAV_HEADER_PARSER_ASSERT_SVH
`define WAV_HEADER_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WAVP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WAVP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/wavp_pkg.sv
// ----------------------------------------------------------------------------
// WAV header parser package
// Payload types, register indexes and RIFF/WAVE constants.
// ----------------------------------------------------------------------------
package wavp_pkg;

   localparam int BYTE_W    = 8;
   localparam int WORD_W    = 32;
   localparam int HALF_W    = 16;
   localparam int CFG_W     = 32;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EXPECTED_RATE     = 2'd0,
      CSR_EXPECTED_CHANNELS = 2'd1,
      CSR_EXPECTED_BITS     = 2'd2
   } wavp_csr_index_type;

   localparam logic [WORD_W-1:0] RESET_RATE     = 32'd16000;
   localparam logic [HALF_W-1:0] RESET_CHANNELS = 16'd1;
   localparam logic [HALF_W-1:0] RESET_BITS     = 16'd16;

   localparam logic [WORD_W-1:0] RIFF_MAGIC  = 32'h52494646;
   localparam logic [WORD_W-1:0] WAVE_MAGIC  = 32'h57415645;
   localparam logic [WORD_W-1:0] TAG_FMT     = 32'h666D7420;
   localparam logic [WORD_W-1:0] TAG_DATA    = 32'h64617461;
   localparam logic [WORD_W-1:0] FMT_MIN_LEN = 32'd16;
   localparam logic [HALF_W-1:0] PCM_TAG     = 16'd1;

   localparam logic [3:0] RIFF_LAST_IDX = 4'd11;
   localparam logic [3:0] HDR_LAST_IDX  = 4'd7;
   localparam logic [3:0] FMT_LAST_IDX  = 4'd15;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_value;
      logic              first_byte;
      logic              last_byte;
   } wavp_req_type;

   typedef struct packed {
      logic              accepted;
      logic [WORD_W-1:0] payload_offset;
      logic [WORD_W-1:0] payload_size;
   } wavp_rsp_type;

   // request held in the input register
   typedef struct packed {
      logic         valid;
      wavp_req_type data;
   } wavp_item_type;

   // verdict headed for the result register
   typedef struct packed {
      logic         valid;
      wavp_rsp_type data;
   } wavp_result_type;

   // {compare, byte} for a byte of the 12-byte file header
   function automatic logic [BYTE_W:0] riff_expect(input logic [3:0] k);
      logic [BYTE_W:0] want;
      unique case (k)
         4'd0:    want = {1'b1, RIFF_MAGIC[31:24]};
         4'd1:    want = {1'b1, RIFF_MAGIC[23:16]};
         4'd2:    want = {1'b1, RIFF_MAGIC[15:8]};
         4'd3:    want = {1'b1, RIFF_MAGIC[7:0]};
         4'd8:    want = {1'b1, WAVE_MAGIC[31:24]};
         4'd9:    want = {1'b1, WAVE_MAGIC[23:16]};
         4'd10:   want = {1'b1, WAVE_MAGIC[15:8]};
         4'd11:   want = {1'b1, WAVE_MAGIC[7:0]};
         default: want = '0;
      endcase
      return want;
   endfunction

   // {compare, byte} for a byte of the fmt chunk body
   function automatic logic [BYTE_W:0] fmt_expect(
      input logic [3:0]        k,
      input logic [WORD_W-1:0] rate,
      input logic [HALF_W-1:0] chans,
      input logic [HALF_W-1:0] bits
   );
      logic [BYTE_W:0] want;
      unique case (k)
         4'd0:    want = {1'b1, PCM_TAG[7:0]};
         4'd1:    want = {1'b1, PCM_TAG[15:8]};
         4'd2:    want = {1'b1, chans[7:0]};
         4'd3:    want = {1'b1, chans[15:8]};
         4'd4:    want = {1'b1, rate[7:0]};
         4'd5:    want = {1'b1, rate[15:8]};
         4'd6:    want = {1'b1, rate[23:16]};
         4'd7:    want = {1'b1, rate[31:24]};
         4'd14:   want = {1'b1, bits[7:0]};
         4'd15:   want = {1'b1, bits[15:8]};
         default: want = '0;
      endcase
      return want;
   endfunction

endpackage

>>> rtl/core/wavp_stream_if.sv
// ----------------------------------------------------------------------------
// WAV header parser stream channel
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface wavp_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/wavp_in_stage.sv
// ----------------------------------------------------------------------------
// WAV header parser input register
// Holds one request until the parse engine consumes it.
// ----------------------------------------------------------------------------
module wavp_in_stage (
   input  logic                    clock,
   input  logic                    reset,
   wavp_stream_if.sink             req_chan,
   input  logic                    in_advance,
   output wavp_pkg::wavp_item_type in_item
);
   import wavp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   wavp_req_type data_ff;
   logic         take;

   assign req_chan.ready = !valid_ff || in_advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      priority if (take) begin
         valid_in = 1'b1;
      end else if (in_advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= req_chan.payload;
      end
   end

   assign in_item.valid = valid_ff;
   assign in_item.data  = data_ff;
endmodule

>>> rtl/core/wavp_parse_engine.sv
// ----------------------------------------------------------------------------
// WAV header parser engine
// Per-byte header walk, configuration registers and verdict generation.
// ----------------------------------------------------------------------------
`include "wav_header_parser_assert.svh"

module wavp_parse_engine (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [wavp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wavp_pkg::CFG_W-1:0]         csr_wr_data,
   input  wavp_pkg::wavp_item_type            in_item,
   input  logic                               slot_free,
   output logic                               in_advance,
   output wavp_pkg::wavp_result_type          result
);
   import wavp_pkg::*;

   typedef enum logic [4:0] {
      PH_RIFF = 5'b00001,
      PH_HDR  = 5'b00010,
      PH_FMT  = 5'b00100,
      PH_SKIP = 5'b01000,
      PH_DONE = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      V_NONE   = 2'd0,
      V_ACCEPT = 2'd1,
      V_REJECT = 2'd2
   } verdict_type;

   // configuration
   logic [WORD_W-1:0] rate_ff;
   logic [HALF_W-1:0] chan_ff;
   logic [HALF_W-1:0] bits_ff;

   // parse state
   phase_type         phase_ff, phase_in, cur_phase;
   logic [3:0]        bif_ff, bif_in, cur_bif;
   logic [WORD_W-1:0] pos_ff, pos_in, cur_pos;
   logic [WORD_W-1:0] tag_ff, tag_in, cur_tag;
   logic [WORD_W-1:0] len_ff, len_in, cur_len;
   logic [WORD_W:0]   skip_ff, skip_in, cur_skip;
   logic              match_ff, match_in, cur_match;
   logic              fmt_ok_ff, fmt_ok_in, cur_fmt_ok;

   logic              step_en;
   logic              active;
   logic              go_hdr;
   logic              match_n;
   logic [BYTE_W:0]   want;
   logic [BYTE_W-1:0] b;
   logic [WORD_W-1:0] tag_w;
   logic [WORD_W-1:0] len_w;
   logic [WORD_W:0]   skip_w;
   verdict_type       verdict;

   assign step_en    = in_item.valid && slot_free;
   assign in_advance = step_en;
   assign b          = in_item.data.byte_value;

   // a first byte restarts the walk before this byte is looked at
   always_comb begin
      if (in_item.data.first_byte) begin
         cur_phase  = PH_RIFF;
         cur_bif    = '0;
         cur_pos    = '0;
         cur_tag    = '0;
         cur_len    = '0;
         cur_skip   = '0;
         cur_match  = 1'b1;
         cur_fmt_ok = 1'b0;
      end else begin
         cur_phase  = phase_ff;
         cur_bif    = bif_ff;
         cur_pos    = pos_ff;
         cur_tag    = tag_ff;
         cur_len    = len_ff;
         cur_skip   = skip_ff;
         cur_match  = match_ff;
         cur_fmt_ok = fmt_ok_ff;
      end
   end

   always_comb begin
      phase_in  = cur_phase;
      bif_in    = cur_bif;
      pos_in    = cur_pos;
      tag_in    = cur_tag;
      len_in    = cur_len;
      skip_in   = cur_skip;
      match_in  = cur_match;
      fmt_ok_in = cur_fmt_ok;
      active    = 1'b1;
      go_hdr    = 1'b0;
      verdict   = V_NONE;
      want      = '0;
      match_n   = cur_match;
      tag_w     = cur_tag;
      len_w     = cur_len;
      skip_w    = '0;

      unique case (cur_phase)
         PH_RIFF: begin
            want     = riff_expect(cur_bif);
            match_n  = cur_match && !(want[BYTE_W] && (b != want[BYTE_W-1:0]));
            match_in = match_n;
            if (cur_bif >= RIFF_LAST_IDX) begin
               if (match_n) begin
                  go_hdr = 1'b1;
               end else begin
                  verdict = V_REJECT;
               end
            end else begin
               bif_in = cur_bif + 4'd1;
            end
         end
         PH_HDR: begin
            if (cur_bif < 4'd4) begin
               tag_w = {cur_tag[WORD_W-BYTE_W-1:0], b};
            end
            // size bytes arrive little-endian
            if (cur_bif[3:2] == 2'b01) begin
               unique case (cur_bif[1:0])
                  2'd0: len_w[7:0]   = cur_len[7:0]   | b;
                  2'd1: len_w[15:8]  = cur_len[15:8]  | b;
                  2'd2: len_w[23:16] = cur_len[23:16] | b;
                  2'd3: len_w[31:24] = cur_len[31:24] | b;
                  default: len_w = cur_len;
               endcase
            end
            tag_in = tag_w;
            len_in = len_w;
            skip_w = {1'b0, len_w} + {{WORD_W{1'b0}}, len_w[0]};
            if (cur_bif < HDR_LAST_IDX) begin
               bif_in = cur_bif + 4'd1;
            end else if (tag_w == TAG_FMT) begin
               if (len_w < FMT_MIN_LEN) begin
                  verdict = V_REJECT;
               end else begin
                  phase_in = PH_FMT;
                  bif_in   = '0;
                  match_in = 1'b1;
               end
            end else if (tag_w == TAG_DATA) begin
               if (!cur_fmt_ok || (len_w == '0)) begin
                  verdict = V_REJECT;
               end else begin
                  verdict = V_ACCEPT;
               end
            end else begin
               skip_in = skip_w;
               if (skip_w == '0) begin
                  go_hdr = 1'b1;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_FMT: begin
            want     = fmt_expect(cur_bif, rate_ff, chan_ff, bits_ff);
            match_n  = cur_match && !(want[BYTE_W] && (b != want[BYTE_W-1:0]));
            match_in = match_n;
            skip_w   = {1'b0, cur_len - FMT_MIN_LEN} + {{WORD_W{1'b0}}, cur_len[0]};
            if (cur_bif < FMT_LAST_IDX) begin
               bif_in = cur_bif + 4'd1;
            end else begin
               fmt_ok_in = match_n;
               skip_in   = skip_w;
               if (skip_w == '0) begin
                  go_hdr = 1'b1;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            skip_in = cur_skip - {{WORD_W{1'b0}}, 1'b1};
            if (cur_skip <= {{WORD_W{1'b0}}, 1'b1}) begin
               skip_in = '0;
               go_hdr  = 1'b1;
            end
         end
         PH_DONE: begin
            active = 1'b0;
         end
         default: begin
            active = 1'b0;
         end
      endcase

      if (go_hdr) begin
         phase_in = PH_HDR;
         bif_in   = '0;
         tag_in   = '0;
         len_in   = '0;
      end

      if (active) begin
         if ((verdict == V_NONE) && in_item.data.last_byte) begin
            verdict = V_REJECT;
         end
         // the position after the last representable one cannot be held
         if ((verdict != V_REJECT) && (cur_pos == {WORD_W{1'b1}})) begin
            verdict = V_REJECT;
         end
         pos_in = cur_pos + 32'd1;
         if (verdict != V_NONE) begin
            phase_in = PH_DONE;
         end
      end
   end

   always_comb begin
      result.valid = step_en && active && (verdict != V_NONE);
      if (verdict == V_ACCEPT) begin
         result.data.accepted       = 1'b1;
         result.data.payload_offset = cur_pos + 32'd1;
         result.data.payload_size   = len_w;
      end else begin
         result.data.accepted       = 1'b0;
         result.data.payload_offset = '0;
         result.data.payload_size   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RESET_RATE;
         chan_ff <= RESET_CHANNELS;
         bits_ff <= RESET_BITS;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_EXPECTED_RATE:     rate_ff <= csr_wr_data;
            CSR_EXPECTED_CHANNELS: chan_ff <= csr_wr_data[HALF_W-1:0];
            CSR_EXPECTED_BITS:     bits_ff <= csr_wr_data[HALF_W-1:0];
            default: begin
               rate_ff <= rate_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_RIFF;
         bif_ff    <= '0;
         pos_ff    <= '0;
         tag_ff    <= '0;
         len_ff    <= '0;
         skip_ff   <= '0;
         match_ff  <= 1'b1;
         fmt_ok_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         bif_ff    <= bif_in;
         pos_ff    <= pos_in;
         tag_ff    <= tag_in;
         len_ff    <= len_in;
         skip_ff   <= skip_in;
         match_ff  <= match_in;
         fmt_ok_ff <= fmt_ok_in;
      end
   end

   `WAVP_ASSERT_NEXT(a_verdict_ends_walk, result.valid, phase_ff == PH_DONE, "verdict did not end the walk")
   `WAVP_ASSERT_SAME(a_done_is_silent, step_en && (phase_ff == PH_DONE) && !in_item.data.first_byte, !result.valid, "result after verdict")
   `WAVP_ASSERT_SAME(a_accept_needs_fmt, result.valid && result.data.accepted, cur_fmt_ok && (result.data.payload_size != '0), "accept without matched fmt chunk")
   `WAVP_ASSERT_SAME(a_skip_nonzero, phase_ff == PH_SKIP, skip_ff != '0, "skip phase with empty count")
endmodule

>>> rtl/core/wavp_out_stage.sv
// ----------------------------------------------------------------------------
// WAV header parser result register
// Holds one verdict until the response side takes it.
// ----------------------------------------------------------------------------
module wavp_out_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  wavp_pkg::wavp_result_type result,
   output logic                      slot_free,
   wavp_stream_if.source             rsp_chan
);
   import wavp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   wavp_rsp_type data_ff;

   assign slot_free = !valid_ff || rsp_chan.ready;

   // hold the result until taken, then load the next one
   always_comb begin
      if (slot_free) begin
         valid_in = result.valid;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_free && result.valid) begin
         data_ff <= result.data;
      end
   end

   assign rsp_chan.valid   = valid_ff;
   assign rsp_chan.payload = data_ff;
endmodule

>>> rtl/core/wav_header_parser.sv
// A request is registered in the input register and its verdict in the result register.
// Throughput: one file byte per cycle while no waiting response stalls the parse step.
// A waiting response stalls the parse step; the input register then takes a request
// only while it is empty.
// Reset is synchronous, active high: the walk restarts at file position zero
// and the expected rate, channels and bits return to 16000, 1 and 16.
// ----------------------------------------------------------------------------
// WAV header parser
// Byte-serial RIFF/WAVE header check giving data payload offset and size.
// ----------------------------------------------------------------------------
module wav_header_parser (
   input  logic                           clock,
   input  logic                           reset,
   wavp_stream_if.sink                    req_chan,
   wavp_stream_if.source                  rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [wavp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wavp_pkg::CFG_W-1:0]     csr_wr_data
);
   import wavp_pkg::*;

   wavp_item_type   in_item;
   wavp_result_type result;
   logic            in_advance;
   logic            slot_free;

   wavp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .in_advance (in_advance),
      .in_item    (in_item)
   );

   wavp_parse_engine u_parse_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .in_item     (in_item),
      .slot_free   (slot_free),
      .in_advance  (in_advance),
      .result      (result)
   );

   wavp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .slot_free (slot_free),
      .rsp_chan  (rsp_chan)
   );
endmodule
